// ===== design/llde_pkg.sv =====
`timescale 1ns / 1ps

package llde_pkg;

	localparam int HANDLE_W = 8;
	localparam int CNT_W    = 9;
	localparam int POS_W    = 8;

	// Command codes on the opcode field.
	localparam logic [3:0] OP_PUSH_FRONT = 4'd0;
	localparam logic [3:0] OP_PUSH_BACK  = 4'd1;
	localparam logic [3:0] OP_POP_FRONT  = 4'd2;
	localparam logic [3:0] OP_POP_BACK   = 4'd3;
	localparam logic [3:0] OP_PEEK       = 4'd4;
	localparam logic [3:0] OP_REMOVE     = 4'd5;
	localparam logic [3:0] OP_FIND_FRONT = 4'd6;
	localparam logic [3:0] OP_FIND_BACK  = 4'd7;
	localparam logic [3:0] OP_CLEAR      = 4'd8;

	// Status codes on the result beat.
	localparam logic [1:0] ST_OK       = 2'd0;
	localparam logic [1:0] ST_RANGE    = 2'd1;
	localparam logic [1:0] ST_LISTED   = 2'd2;
	localparam logic [1:0] ST_UNLISTED = 2'd3;

	// Operation broadcast to every cell of the chain.
	typedef enum logic [2:0] {
		C_HOLD,
		C_LOAD,
		C_SHIFT,
		C_PUSHF,
		C_PUSHB,
		C_DEL
	} cell_op_t;

	typedef struct packed {
		cell_op_t              op;
		logic [HANDLE_W-1:0]   key;
		logic [CNT_W-1:0]      cnt;
		logic [CNT_W-1:0]      pos;
	} cell_ctl_t;

endpackage

// ===== design/llde_cell.sv =====
`timescale 1ns / 1ps

module llde_cell import llde_pkg::*; #(
	parameter logic [CNT_W-1:0] CELL_IDX = '0
) (
	input  logic                clk,
	input  cell_ctl_t           ctl,
	input  logic [HANDLE_W-1:0] left_h,
	input  logic [HANDLE_W-1:0] right_h,
	input  logic [HANDLE_W-1:0] right_ans_h,
	input  logic                right_ans_m,
	output logic [HANDLE_W-1:0] h,
	output logic [HANDLE_W-1:0] ans_h,
	output logic                ans_m
);

	logic [HANDLE_W-1:0] h_q;
	logic [HANDLE_W-1:0] ans_h_q;
	logic                ans_m_q;

	// The list entry held at this position, moved by pushes and deletions.
	always_ff @(posedge clk) begin
		unique case (ctl.op)
			C_PUSHF: h_q <= left_h;
			C_PUSHB: if (CELL_IDX == ctl.cnt) h_q <= ctl.key;
			C_DEL:   if (CELL_IDX >= ctl.pos) h_q <= right_h;
			default: h_q <= h_q;
		endcase
	end

	// The answer row: loaded from the entries, then walked towards cell zero.
	always_ff @(posedge clk) begin
		unique case (ctl.op)
			C_LOAD: begin
				ans_h_q <= h_q;
				ans_m_q <= (h_q == ctl.key) && (CELL_IDX < ctl.cnt);
			end
			C_SHIFT: begin
				ans_h_q <= right_ans_h;
				ans_m_q <= right_ans_m;
			end
			default: begin
				ans_h_q <= ans_h_q;
				ans_m_q <= ans_m_q;
			end
		endcase
	end

	assign h     = h_q;
	assign ans_h = ans_h_q;
	assign ans_m = ans_m_q;

endmodule

// ===== design/linked_list_deque_engine_core.sv =====
`timescale 1ns / 1ps
// Clear, refused and unknown commands answer in the cycle after the beat is taken; scans
// walk the answer row one list position at a time until a hit or the end of the list,
// and pushes, pops and removals then update the chain in the apply state.
// One command at a time: a new beat is taken only when idle and the result register is free.
// Reset clears the entry count, the control state and the result register; the chain cells
// need no reset.
module linked_list_deque_engine_core import llde_pkg::*; #(
	parameter int HANDLE_SLOTS = 256
) (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                item_valid,
	output logic                item_stall,
	input  logic [3:0]          opcode,
	input  logic [HANDLE_W-1:0] handle,
	input  logic [POS_W-1:0]    position,
	output logic                result_valid,
	input  logic                result_stall,
	output logic [HANDLE_W-1:0] result_handle,
	output logic                handle_valid,
	output logic [POS_W-1:0]    found_position,
	output logic [CNT_W-1:0]    entry_count,
	output logic                list_empty,
	output logic [1:0]          status
);

	localparam int NCELL = (HANDLE_SLOTS < 256) ? HANDLE_SLOTS : 256;

	typedef enum logic [2:0] {
		S_IDLE  = 3'b001,
		S_SCAN  = 3'b010,
		S_APPLY = 3'b100
	} state_t;

	state_t              state_q;
	logic [3:0]          op_q;
	logic [HANDLE_W-1:0] key_q;
	logic [CNT_W-1:0]    pos_q;
	logic [CNT_W-1:0]    cnt_q;
	logic [CNT_W-1:0]    k_q;
	logic                walk_q;

	logic                rv_q;
	logic [HANDLE_W-1:0] rh_q;
	logic                rhv_q;
	logic [POS_W-1:0]    rpos_q;
	logic [CNT_W-1:0]    rcnt_q;
	logic [1:0]          rst_q;

	cell_ctl_t           ctl;
	logic [HANDLE_W-1:0] cell_h   [NCELL];
	logic [HANDLE_W-1:0] cell_ah  [NCELL];
	logic                cell_am  [NCELL];

	logic                out_free;
	logic                accept;
	logic                hit;
	logic                miss;
	logic                key_bad;
	logic [CNT_W-1:0]    back_k;

	assign out_free   = !rv_q || !result_stall;
	assign accept     = item_valid && (state_q == S_IDLE) && out_free;
	assign item_stall = !((state_q == S_IDLE) && out_free);
	assign key_bad    = int'(handle) >= HANDLE_SLOTS;

	// Scan outcome at the head of the answer row.
	always_comb begin
		hit  = 1'b0;
		miss = 1'b0;
		if (walk_q) begin
			hit = (k_q == pos_q);
		end else if (k_q == cnt_q) begin
			miss = 1'b1;
		end else begin
			hit = cell_am[0];
		end
	end

	assign back_k = cnt_q - 9'd1 - k_q;

	// Operation broadcast to the chain.
	always_comb begin
		ctl.op  = C_HOLD;
		ctl.key = (state_q == S_IDLE) ? handle : key_q;
		ctl.cnt = cnt_q;
		ctl.pos = pos_q;
		unique case (state_q)
			S_IDLE:  if (accept) ctl.op = C_LOAD;
			S_SCAN:  if (!hit && !miss) ctl.op = C_SHIFT;
			S_APPLY: begin
				if (out_free) begin
					priority if (op_q == OP_PUSH_FRONT) ctl.op = C_PUSHF;
					else if (op_q == OP_PUSH_BACK) ctl.op = C_PUSHB;
					else ctl.op = C_DEL;
				end
			end
			default: ctl.op = C_HOLD;
		endcase
	end

	// The chain of cells, one per list position.
	for (genvar i = 0; i < NCELL; i++) begin : g_cell
		logic [HANDLE_W-1:0] lh;
		logic [HANDLE_W-1:0] rh;
		logic [HANDLE_W-1:0] rah;
		logic                ram;
		if (i == 0) begin : g_first
			assign lh = ctl.key;
		end else begin : g_mid
			assign lh = cell_h[i-1];
		end
		if (i == NCELL - 1) begin : g_last
			assign rh  = cell_h[i];
			assign rah = '0;
			assign ram = 1'b0;
		end else begin : g_inner
			assign rh  = cell_h[i+1];
			assign rah = cell_ah[i+1];
			assign ram = cell_am[i+1];
		end
		llde_cell #(.CELL_IDX(CNT_W'(i))) u_cell (
			.clk         (clk),
			.ctl         (ctl),
			.left_h      (lh),
			.right_h     (rh),
			.right_ans_h (rah),
			.right_ans_m (ram),
			.h           (cell_h[i]),
			.ans_h       (cell_ah[i]),
			.ans_m       (cell_am[i])
		);
	end

	// Command payload registers.
	always_ff @(posedge clk) begin
		if (accept) begin
			op_q   <= opcode;
			key_q  <= handle;
			walk_q <= (opcode == OP_POP_FRONT) || (opcode == OP_POP_BACK) ||
				(opcode == OP_PEEK);
			pos_q  <= (opcode == OP_POP_BACK) ? (cnt_q - 9'd1 - {1'b0, position})
				: {1'b0, position};
		end else if (state_q == S_SCAN && hit) begin
			pos_q <= k_q;
		end
		if (accept) begin
			k_q <= '0;
		end else if (state_q == S_SCAN && !hit && !miss) begin
			k_q <= k_q + 9'd1;
		end
	end

	// Sequencer, entry count and result register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
			cnt_q   <= '0;
			rv_q    <= 1'b0;
			rh_q    <= '0;
			rhv_q   <= 1'b0;
			rpos_q  <= '0;
			rcnt_q  <= '0;
			rst_q   <= ST_OK;
		end else begin
			if (rv_q && !result_stall) rv_q <= 1'b0;
			unique case (state_q)
				S_IDLE: begin
					if (accept) begin
						rh_q   <= '0;
						rhv_q  <= 1'b0;
						rpos_q <= '0;
						rcnt_q <= cnt_q;
						priority case (opcode)
							OP_PUSH_FRONT, OP_PUSH_BACK: begin
								if (key_bad) begin
									rst_q <= ST_RANGE;
									rv_q  <= 1'b1;
								end else begin
									state_q <= S_SCAN;
								end
							end
							OP_POP_FRONT, OP_POP_BACK, OP_PEEK: begin
								if ({1'b0, position} >= cnt_q) begin
									rst_q <= ST_RANGE;
									rv_q  <= 1'b1;
								end else begin
									state_q <= S_SCAN;
								end
							end
							OP_REMOVE: begin
								if (key_bad) begin
									rst_q <= ST_UNLISTED;
									rv_q  <= 1'b1;
								end else begin
									state_q <= S_SCAN;
								end
							end
							OP_FIND_FRONT, OP_FIND_BACK: begin
								if (key_bad) begin
									rst_q <= ST_RANGE;
									rv_q  <= 1'b1;
								end else begin
									state_q <= S_SCAN;
								end
							end
							OP_CLEAR: begin
								cnt_q  <= '0;
								rcnt_q <= '0;
								rst_q  <= ST_OK;
								rv_q   <= 1'b1;
							end
							default: begin
								rst_q <= ST_RANGE;
								rv_q  <= 1'b1;
							end
						endcase
					end
				end
				S_SCAN: begin
					if (hit || miss) begin
						priority case (op_q)
							OP_PUSH_FRONT, OP_PUSH_BACK: begin
								if (miss) begin
									state_q <= S_APPLY;
								end else if (out_free) begin
									rh_q    <= key_q;
									rhv_q   <= 1'b1;
									rst_q   <= ST_LISTED;
									rv_q    <= 1'b1;
									state_q <= S_IDLE;
								end
							end
							OP_POP_FRONT, OP_POP_BACK: state_q <= S_APPLY;
							OP_REMOVE: begin
								if (hit) begin
									state_q <= S_APPLY;
								end else if (out_free) begin
									rst_q   <= ST_UNLISTED;
									rv_q    <= 1'b1;
									state_q <= S_IDLE;
								end
							end
							OP_PEEK: begin
								if (out_free) begin
									rh_q    <= cell_ah[0];
									rhv_q   <= 1'b1;
									rst_q   <= ST_OK;
									rv_q    <= 1'b1;
									state_q <= S_IDLE;
								end
							end
							default: begin
								if (out_free) begin
									if (hit) begin
										rh_q   <= key_q;
										rhv_q  <= 1'b1;
										rpos_q <= (op_q == OP_FIND_BACK) ? back_k[POS_W-1:0]
											: k_q[POS_W-1:0];
										rst_q  <= ST_OK;
									end else begin
										rst_q  <= ST_RANGE;
									end
									rv_q    <= 1'b1;
									state_q <= S_IDLE;
								end
							end
						endcase
					end
				end
				S_APPLY: begin
					if (out_free) begin
						rhv_q <= 1'b1;
						rst_q <= ST_OK;
						rv_q  <= 1'b1;
						if (op_q == OP_PUSH_FRONT || op_q == OP_PUSH_BACK) begin
							rh_q   <= key_q;
							cnt_q  <= cnt_q + 9'd1;
							rcnt_q <= cnt_q + 9'd1;
						end else begin
							rh_q   <= (op_q == OP_REMOVE) ? key_q : cell_ah[0];
							cnt_q  <= cnt_q - 9'd1;
							rcnt_q <= cnt_q - 9'd1;
						end
						state_q <= S_IDLE;
					end
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

	assign result_valid   = rv_q;
	assign result_handle  = rh_q;
	assign handle_valid   = rhv_q;
	assign found_position = rpos_q;
	assign entry_count    = rcnt_q;
	assign list_empty     = (rcnt_q == '0);
	assign status         = rst_q;

endmodule
